/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL files.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hw/rtl/bwb_pkg.sv */
// Shared types and constants for the black-white bakery arbiter.
// No dependencies; used by the other RTL modules and interfaces.
`timescale 1ns / 1ps

package bwb_pkg;

  localparam int TICKET_W = 5;
  localparam int ID_W     = 4;
  // requester field is 4 bits, so at most this many entries can ever be used
  localparam int MAX_IDS  = 1 << ID_W;

  localparam logic [TICKET_W-1:0] TICKET_MAX = 5'd31;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_IGNORED = 1'b1;

  typedef struct packed {
    logic                color;
    logic [TICKET_W-1:0] ticket;
  } entry_t;

  typedef struct packed {
    logic clr_max;
    logic clr_pick;
    logic max_en;
    logic pick_en;
  } scan_ctl_t;

  typedef struct packed {
    logic [TICKET_W-1:0] max_ticket;
    logic                own_busy;
    logic                found;
    logic [ID_W-1:0]     best_id;
    logic                best_color;
  } scan_res_t;

endpackage

/* hw/rtl/bwb_if.sv */
// Valid/ready channel interfaces for arbiter requests and responses.
// Depends on bwb_pkg for field widths.
`timescale 1ns / 1ps

interface bwb_req_if;
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [bwb_pkg::ID_W-1:0] requester;

  modport source (output valid, operation, requester, input ready);
  modport sink   (input valid, operation, requester, output ready);
endinterface

interface bwb_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic [bwb_pkg::TICKET_W-1:0] ticket;
  logic                         tkt_color;
  logic                         granted;
  logic [bwb_pkg::ID_W-1:0]     grant_id;
  logic                         lock_color_now;

  modport source (output valid, status, ticket, tkt_color, granted, grant_id,
                  lock_color_now, input ready);
  modport sink   (input valid, status, ticket, tkt_color, granted, grant_id,
                  lock_color_now, output ready);
endinterface

/* hw/rtl/black_white_bakery_arbiter.sv */
// Black-white bakery ticket lock arbiter, one request in flight at a time.
// Each request sweeps the ticket memory once for the max ticket and, when the
// lock ends free, once more for the grant pick, one word a cycle; no new request
// is accepted until the response has been loaded into the output register.
// Synchronous reset clears all tickets, shared color and holder at once.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module black_white_bakery_arbiter #(
  parameter int CLIENTS = 16
) (
  input  logic             clk,
  input  logic             rst,
  bwb_req_if.sink          req,
  bwb_rsp_if.source        rsp
);

  localparam int ENTRIES = (CLIENTS < bwb_pkg::MAX_IDS) ? CLIENTS : bwb_pkg::MAX_IDS;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0]        LAST      = IDX_W'(ENTRIES - 1);
  localparam logic [bwb_pkg::ID_W:0]  ENTRIES_W = (bwb_pkg::ID_W + 1)'(ENTRIES);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_SCAN_MAX  = 6'b000010,
    S_WRITE     = 6'b000100,
    S_SCAN_PICK = 6'b001000,
    S_GRANT     = 6'b010000,
    S_OUT       = 6'b100000
  } state_t;

  state_t state, state_next;

  logic                         op_q;
  logic [bwb_pkg::ID_W-1:0]     req_q;
  logic                         lock_color;
  logic                         holder_valid;
  logic [bwb_pkg::ID_W-1:0]     holder_id;

  logic [IDX_W-1:0]             cnt;
  logic                         rd_valid;
  logic [IDX_W-1:0]             rd_idx;
  logic                         issue, scan_end;

  logic                         res_status;
  logic [bwb_pkg::TICKET_W-1:0] res_ticket;
  logic                         res_color;
  logic                         res_granted;
  logic [bwb_pkg::ID_W-1:0]     res_gid;

  logic                         out_valid;
  logic                         out_status;
  logic [bwb_pkg::TICKET_W-1:0] out_ticket;
  logic                         out_color;
  logic                         out_granted;
  logic [bwb_pkg::ID_W-1:0]     out_gid;
  logic                         out_shared;

  bwb_pkg::entry_t              rd_data, wdata;
  bwb_pkg::scan_ctl_t           scan_ctl;
  bwb_pkg::scan_res_t           scan_res;

  logic accept, in_range, req_ok, rel_ok, mem_we, out_load;
  logic [bwb_pkg::TICKET_W-1:0] new_ticket;

  assign accept   = req.valid && req.ready;
  assign req.ready = state == S_IDLE;

  assign in_range   = {1'b0, req_q} < ENTRIES_W;
  assign new_ticket = (scan_res.max_ticket >= bwb_pkg::TICKET_MAX) ? bwb_pkg::TICKET_MAX
                                                                   : scan_res.max_ticket + 1'b1;
  assign req_ok = state == S_WRITE && op_q == bwb_pkg::OP_REQUEST && in_range &&
                  !scan_res.own_busy;
  assign rel_ok = state == S_WRITE && op_q == bwb_pkg::OP_RELEASE && in_range &&
                  holder_valid && holder_id == req_q;
  assign mem_we = req_ok || rel_ok;
  // a release writes a zero ticket, which frees the entry
  assign wdata  = req_ok ? bwb_pkg::entry_t'{color: lock_color, ticket: new_ticket} : '0;

  assign issue    = state == S_SCAN_MAX || state == S_SCAN_PICK;
  assign scan_end = issue && rd_valid && rd_idx == LAST;

  assign scan_ctl.clr_max  = accept;
  assign scan_ctl.clr_pick = state == S_WRITE;
  assign scan_ctl.max_en   = state == S_SCAN_MAX && rd_valid;
  assign scan_ctl.pick_en  = state == S_SCAN_PICK && rd_valid;

  assign out_load = state == S_OUT && (!out_valid || rsp.ready);

  bwb_mem #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (req_q[IDX_W-1:0]),
    .wdata (wdata),
    .raddr (cnt),
    .rdata (rd_data)
  );

  bwb_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctl       (scan_ctl),
    .rd_data   (rd_data),
    .rd_idx    (bwb_pkg::ID_W'(rd_idx)),
    .color     (lock_color),
    .requester (req_q),
    .res       (scan_res)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_SCAN_MAX;
      end
      S_SCAN_MAX: begin
        if (scan_end) state_next = S_WRITE;
      end
      S_WRITE: begin
        // grant check only when the lock is free after this update
        if (holder_valid && !rel_ok) state_next = S_OUT;
        else state_next = S_SCAN_PICK;
      end
      S_SCAN_PICK: begin
        if (scan_end) state_next = S_GRANT;
      end
      S_GRANT: state_next = S_OUT;
      S_OUT: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      lock_color   <= 1'b0;
      holder_valid <= 1'b0;
      holder_id    <= '0;
      cnt          <= '0;
      rd_valid     <= 1'b0;
      rd_idx       <= '0;
      out_valid    <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      rd_idx   <= cnt;
      if (!issue || scan_end) begin
        cnt <= '0;
      end else begin
        cnt <= (cnt == LAST) ? '0 : cnt + 1'b1;
      end
      if (rel_ok) begin
        holder_valid <= 1'b0;
        holder_id    <= '0;
      end
      if (state == S_GRANT && scan_res.found) begin
        holder_valid <= 1'b1;
        holder_id    <= scan_res.best_id;
        if (scan_res.best_color == lock_color) begin
          lock_color <= ~lock_color;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q        <= req.operation;
      req_q       <= req.requester;
      res_status  <= bwb_pkg::STATUS_IGNORED;
      res_ticket  <= '0;
      res_color   <= 1'b0;
      res_granted <= 1'b0;
      res_gid     <= '0;
    end
    if (mem_we) begin
      res_status <= bwb_pkg::STATUS_OK;
    end
    if (req_ok) begin
      res_ticket <= new_ticket;
      res_color  <= lock_color;
    end
    if (state == S_GRANT && scan_res.found) begin
      res_granted <= 1'b1;
      res_gid     <= scan_res.best_id;
    end
    if (out_load) begin
      out_status  <= res_status;
      out_ticket  <= res_ticket;
      out_color   <= res_color;
      out_granted <= res_granted;
      out_gid     <= res_gid;
      out_shared  <= lock_color;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.ticket         = out_ticket;
  assign rsp.tkt_color      = out_color;
  assign rsp.granted        = out_granted;
  assign rsp.grant_id       = out_gid;
  assign rsp.lock_color_now = out_shared;

  `ASSERT_IMPL(a_holder_in_range, clk, rst, holder_valid, ({1'b0, holder_id} < ENTRIES_W))
  `ASSERT_NEXT(a_release_frees, clk, rst, rel_ok, !holder_valid)
  `ASSERT_NEXT(a_grant_takes, clk, rst, state == S_GRANT && scan_res.found, holder_valid)
  `ASSERT_IMPL(a_ticket_ok, clk, rst, rsp.valid && rsp.ticket != '0,
               rsp.status == bwb_pkg::STATUS_OK)

endmodule

/* hw/rtl/bwb_mem.sv */
// Ticket store: one synchronous memory of {color, ticket} per client.
// Per-entry valid bits make unwritten entries read as zero. Uses bwb_pkg.
`timescale 1ns / 1ps

module bwb_mem #(
  parameter int ENTRIES = 16,
  parameter int IDX_W   = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                we,
  input  logic [IDX_W-1:0]    waddr,
  input  bwb_pkg::entry_t     wdata,
  input  logic [IDX_W-1:0]    raddr,
  output bwb_pkg::entry_t     rdata
);

  bwb_pkg::entry_t mem [ENTRIES];
  logic [ENTRIES-1:0] vbits;
  bwb_pkg::entry_t rd_entry;
  logic rd_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_entry <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        vbits[waddr] <= 1'b1;
      end
      rd_vld <= vbits[raddr];
    end
  end

  assign rdata = rd_vld ? rd_entry : '0;

endmodule

/* hw/rtl/bwb_scan.sv */
// Scan accumulators: max ticket of a color, requester's own entry, and
// the grant pick (other color first, then lowest ticket, then lowest id).
// Uses bwb_pkg; fed one memory word per cycle by the sequencer.
`timescale 1ns / 1ps

module bwb_scan (
  input  logic                       clk,
  input  logic                       rst,
  input  bwb_pkg::scan_ctl_t         ctl,
  input  bwb_pkg::entry_t            rd_data,
  input  logic [bwb_pkg::ID_W-1:0]   rd_idx,
  input  logic                       color,
  input  logic [bwb_pkg::ID_W-1:0]   requester,
  output bwb_pkg::scan_res_t         res
);

  logic [bwb_pkg::TICKET_W-1:0] max_ticket;
  logic                         own_busy;
  logic                         found;
  logic                         best_pref;
  logic [bwb_pkg::ID_W-1:0]     best_id;
  logic [bwb_pkg::TICKET_W-1:0] best_ticket;
  logic                         best_color;
  logic live, pref, take;

  assign live = rd_data.ticket != '0;
  assign pref = rd_data.color != color;
  // strict less-than keeps the earlier (lower) id on ties
  assign take = live && (!found || (pref && !best_pref) ||
                         (pref == best_pref && rd_data.ticket < best_ticket));

  always_ff @(posedge clk) begin
    if (rst || ctl.clr_max) begin
      max_ticket <= '0;
      own_busy   <= 1'b0;
    end else if (ctl.max_en) begin
      if (live && rd_data.color == color && rd_data.ticket > max_ticket) begin
        max_ticket <= rd_data.ticket;
      end
      if (rd_idx == requester) begin
        own_busy <= live;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr_pick) begin
      found       <= 1'b0;
      best_pref   <= 1'b0;
      best_id     <= '0;
      best_ticket <= '0;
      best_color  <= 1'b0;
    end else if (ctl.pick_en && take) begin
      found       <= 1'b1;
      best_pref   <= pref;
      best_id     <= rd_idx;
      best_ticket <= rd_data.ticket;
      best_color  <= rd_data.color;
    end
  end

  assign res.max_ticket = max_ticket;
  assign res.own_busy   = own_busy;
  assign res.found      = found;
  assign res.best_id    = best_id;
  assign res.best_color = best_color;

endmodule

/* dv/testbench.sv */
// Self-checking testbench for black_white_bakery_arbiter: lock requests in, grant replies out.
// Depends on bwb_pkg and the bwb_req_if / bwb_rsp_if interfaces from the RTL.
`timescale 1ns / 1ps

typedef struct packed {
  logic                         status;
  logic [bwb_pkg::TICKET_W-1:0] ticket;
  logic                         tkt_color;
  logic                         granted;
  logic [bwb_pkg::ID_W-1:0]     grant_id;
  logic                         lock_color_now;
} reply_t;

class lock_tracker;
  logic [bwb_pkg::TICKET_W-1:0] ticket_of [bwb_pkg::MAX_IDS];
  logic                         color_of  [bwb_pkg::MAX_IDS];
  logic                         lock_color;
  logic                         held;
  logic [bwb_pkg::ID_W-1:0]     holder;
  reply_t                       owed[$];
  int                           errors;

  function new();
    foreach (ticket_of[i]) begin
      ticket_of[i] = '0;
      color_of[i]  = 1'b0;
    end
    lock_color = 1'b0;
    held       = 1'b0;
    holder     = '0;
    errors     = 0;
  endfunction

  // one above the largest live ticket of this color, saturating
  function logic [bwb_pkg::TICKET_W-1:0] next_ticket(logic c);
    logic [bwb_pkg::TICKET_W-1:0] top;
    top = '0;
    foreach (ticket_of[i])
      if (ticket_of[i] != 0 && color_of[i] == c && ticket_of[i] > top) top = ticket_of[i];
    return (top >= bwb_pkg::TICKET_MAX) ? bwb_pkg::TICKET_MAX : top + 1'b1;
  endfunction

  function void note_request(logic op, logic [bwb_pkg::ID_W-1:0] id);
    reply_t                   r;
    logic                     found;
    logic                     best_pref;
    logic                     pref;
    logic [bwb_pkg::ID_W-1:0] best;
    r = '0;
    r.status = bwb_pkg::STATUS_IGNORED;
    if (op == bwb_pkg::OP_REQUEST) begin
      if (int'(id) < bwb_pkg::MAX_IDS && ticket_of[id] == 0) begin
        r.ticket      = next_ticket(lock_color);
        r.tkt_color   = lock_color;
        ticket_of[id] = r.ticket;
        color_of[id]  = lock_color;
        r.status      = bwb_pkg::STATUS_OK;
      end
    end else if (held && holder == id) begin
      ticket_of[id] = '0;
      held          = 1'b0;
      holder        = '0;
      r.status      = bwb_pkg::STATUS_OK;
    end
    if (!held) begin
      found     = 1'b0;
      best_pref = 1'b0;
      best      = '0;
      // other-color waiters first, then lowest ticket, then lowest id
      foreach (ticket_of[i]) begin
        if (ticket_of[i] != 0) begin
          pref = (color_of[i] != lock_color);
          if (!found || (pref && !best_pref) ||
              (pref == best_pref && ticket_of[i] < ticket_of[best])) begin
            found     = 1'b1;
            best_pref = pref;
            best      = bwb_pkg::ID_W'(i);
          end
        end
      end
      if (found) begin
        held   = 1'b1;
        holder = best;
        if (color_of[best] == lock_color) lock_color = ~lock_color;
        r.granted  = 1'b1;
        r.grant_id = best;
      end
    end
    r.lock_color_now = lock_color;
    owed.push_back(r);
  endfunction

  function string show(reply_t r);
    return $sformatf("status=%0d ticket=%0d color=%0d granted=%0d grant_id=%0d shared=%0d",
                     r.status, r.ticket, r.tkt_color, r.granted, r.grant_id,
                     r.lock_color_now);
  endfunction

  function void check_reply(reply_t got);
    reply_t want;
    if (owed.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected reply: %s", show(got));
    end else begin
      want = owed.pop_front();
      if (got.status !== want.status || got.ticket !== want.ticket ||
          got.tkt_color !== want.tkt_color || got.granted !== want.granted ||
          got.grant_id !== want.grant_id || got.lock_color_now !== want.lock_color_now) begin
        errors++;
        if (errors <= 10) begin
          $display("reply mismatch");
          $display("  expected: %s", show(want));
          $display("  actual:   %s", show(got));
        end
      end
    end
  endfunction
endclass

module testbench;

  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 1700;

  logic clk;
  logic rst;
  bit   steady;
  int   idle_cycles;
  int   stall_left;
  lock_tracker book = new();

  bwb_req_if req_ch();
  bwb_rsp_if rsp_ch();

  black_white_bakery_arbiter #(.CLIENTS(bwb_pkg::MAX_IDS)) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly back to back, sometimes short gaps, rarely long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(logic op, logic [bwb_pkg::ID_W-1:0] id);
    int gap;
    gap = steady ? 0 : gap_len();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.requester <= id;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    book.note_request(op, id);
  endtask

  task automatic run_directed();
    logic [bwb_pkg::ID_W-1:0] fill_ids[$];
    fill_ids = '{4'd1, 4'd2, 4'd4, 4'd5, 4'd6, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14};
    send_request(bwb_pkg::OP_REQUEST, 4'd0);   // free lock: immediate grant, color flips
    send_request(bwb_pkg::OP_REQUEST, 4'd15);
    send_request(bwb_pkg::OP_REQUEST, 4'd0);   // duplicate
    send_request(bwb_pkg::OP_RELEASE, 4'd15);  // release by a waiter
    send_request(bwb_pkg::OP_REQUEST, 4'd7);
    send_request(bwb_pkg::OP_REQUEST, 4'd3);
    send_request(bwb_pkg::OP_RELEASE, 4'd0);
    send_request(bwb_pkg::OP_REQUEST, 4'd8);   // other color from here on
    send_request(bwb_pkg::OP_RELEASE, 4'd15);
    send_request(bwb_pkg::OP_RELEASE, 4'd7);
    send_request(bwb_pkg::OP_RELEASE, 4'd3);
    send_request(bwb_pkg::OP_RELEASE, 4'd8);   // lock ends free, nobody waiting
    send_request(bwb_pkg::OP_RELEASE, 4'd8);   // release with the lock free
    foreach (fill_ids[i]) send_request(bwb_pkg::OP_REQUEST, fill_ids[i]);
  endtask

  task automatic run_random(int count);
    int                       target;
    int                       busy;
    logic [bwb_pkg::ID_W-1:0] idle_ids[$];
    logic                     op;
    logic [bwb_pkg::ID_W-1:0] id;
    target = bwb_pkg::MAX_IDS;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        target = $urandom_range(1, bwb_pkg::MAX_IDS);
        steady = ($urandom_range(0, 3) == 0);
      end
      busy = 0;
      idle_ids.delete();
      for (int i = 0; i < bwb_pkg::MAX_IDS; i++) begin
        if (book.ticket_of[i] != 0) busy++;
        else idle_ids.push_back(bwb_pkg::ID_W'(i));
      end
      if ($urandom_range(0, 99) < 10) begin
        op = 1'($urandom_range(0, 1));
        id = bwb_pkg::ID_W'($urandom_range(0, bwb_pkg::MAX_IDS - 1));
      end else if (book.held && (busy > target || idle_ids.size() == 0 ||
                                 $urandom_range(0, 99) < 15)) begin
        op = bwb_pkg::OP_RELEASE;
        id = book.holder;
      end else if (idle_ids.size() != 0) begin
        op = bwb_pkg::OP_REQUEST;
        id = idle_ids[$urandom_range(0, idle_ids.size() - 1)];
      end else begin
        op = bwb_pkg::OP_RELEASE;
        id = bwb_pkg::ID_W'($urandom_range(0, bwb_pkg::MAX_IDS - 1));
      end
      send_request(op, id);
    end
  endtask

  initial begin
    rst              = 1'b1;
    steady           = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.operation = bwb_pkg::OP_REQUEST;
    req_ch.requester = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random(RANDOM_ITEMS);
    req_ch.valid <= 1'b0;
    while (book.owed.size() != 0) @(posedge clk);
    repeat (2 * bwb_pkg::MAX_IDS + 8) @(posedge clk);
    if (book.errors == 0 && book.owed.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // reply side: check on handshake, then decide next cycle's ready
  initial begin
    rsp_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready)
        book.check_reply('{rsp_ch.status, rsp_ch.ticket, rsp_ch.tkt_color,
                           rsp_ch.granted, rsp_ch.grant_id, rsp_ch.lock_color_now});
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (!steady && $urandom_range(0, 99) < 20) stall_left = gap_len();
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end
endmodule
